>>> sv/pac_pkg.sv
// ----------------------------------------------------------------------------
// pac_pkg
// Shared codes and types for the portal area connectivity block.
// ----------------------------------------------------------------------------
package pac_pkg;

   typedef enum logic [1:0] {
      REQ_SPAN   = 2'd0,
      REQ_EDGE   = 2'd1,
      REQ_PORTAL = 2'd2,
      REQ_QUERY  = 2'd3
   } pac_req_type;

   typedef enum logic [1:0] {
      STAT_DONE     = 2'd0,
      STAT_IGNORED  = 2'd1,
      STAT_RANGE    = 2'd2,
      STAT_CONFLICT = 2'd3
   } pac_status_type;

   typedef enum logic [1:0] {
      CSR_NUM_AREAS   = 2'd0,
      CSR_LAST_PORTAL = 2'd1,
      CSR_NO_AREAS    = 2'd2
   } pac_csr_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_QUERY,
      ST_VCLR,
      ST_SCAN,
      ST_SCANW,
      ST_SPANW,
      ST_EDGE,
      ST_EDGEW,
      ST_PORTW,
      ST_VISW,
      ST_POPW
   } pac_state_type;

   typedef struct packed {
      logic           valid;
      logic           connected;
      pac_status_type status;
   } pac_rsp_type;

endpackage

>>> sv/pac_ram.sv
// ----------------------------------------------------------------------------
// pac_ram
// Synchronous memory, one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module pac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/portal_area_connectivity.sv
// ----------------------------------------------------------------------------
// portal_area_connectivity
// Area graph with portal-gated edges, flood relabel and pair queries.
// ----------------------------------------------------------------------------
// After reset the block sweeps its portal and label memories with busy
// high. Span and edge loads answer in the cycle after they are taken; a
// query is answered from the query state, which reads both label
// memories, through the registered response. A portal set runs a
// relabel: it clears the visited memory, then scans the areas and walks
// their edges; every step waits on one memory read. busy stays high until
// the answer; results are a one-cycle strobe and cannot stall.
module portal_area_connectivity #(
   parameter int MAX_AREAS   = 256,
   parameter int MAX_EDGES   = 1024,
   parameter int MAX_PORTALS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_area_a,
   input  logic [7:0]  req_area_b,
   input  logic [9:0]  req_edge_index,
   input  logic [10:0] req_edge_count,
   input  logic [9:0]  req_portal_index,
   input  logic        req_open_flag,
   output logic        rsp_valid,
   output logic        rsp_connected,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_wdata
);

   localparam int AW  = $clog2(MAX_AREAS);
   localparam int EW  = $clog2(MAX_EDGES);
   localparam int PW  = $clog2(MAX_PORTALS);
   localparam int CLR = (MAX_AREAS > MAX_PORTALS) ? MAX_AREAS : MAX_PORTALS;
   localparam int CW  = $clog2(CLR);
   localparam int SW  = AW + 11;

   pac_pkg::pac_state_type state_ff, state_in;
   pac_pkg::pac_rsp_type   rsp_ff, rsp_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [AW:0]    i_ff, i_in;
   logic [7:0]     lbl_ff, lbl_in;
   logic [AW:0]    sp_ff, sp_in;
   logic [AW-1:0]  top_area_ff, top_area_in;
   logic [10:0]    top_pos_ff, top_pos_in;
   logic [9:0]     top_first_ff, top_first_in;
   logic [10:0]    top_count_ff, top_count_in;
   logic [AW-1:0]  other_ff, other_in;
   logic           other_ok_ff, other_ok_in;
   logic [7:0]     qa_ff, qa_in;
   logic [7:0]     qb_ff, qb_in;
   logic [8:0]     num_areas_ff;
   logic [9:0]     last_portal_ff;
   logic           no_areas_ff;

   // memory ports
   logic            span_we;
   logic [AW-1:0]   span_raddr;
   logic [20:0]     span_rd;
   logic            edge_we;
   logic [EW-1:0]   edge_raddr;
   logic [17:0]     edge_rd;
   logic            port_we;
   logic [PW-1:0]   port_waddr, port_raddr;
   logic            port_wdata, port_rd;
   logic            lab_we;
   logic [AW-1:0]   lab_waddr, lab_raddr_a, lab_raddr_b;
   logic [7:0]      lab_wdata, lab_rd_a, lab_rd_b;
   logic            vis_we;
   logic [AW-1:0]   vis_waddr, vis_raddr;
   logic            vis_wdata, vis_rd;
   logic            stk_we;
   logic [AW-1:0]   stk_waddr, stk_raddr;
   logic [SW-1:0]   stk_rd;

   logic [AW:0]     n_use;
   logic [11:0]     slot;
   logic            accept;

   assign accept    = start && (state_ff == pac_pkg::ST_IDLE);
   assign busy      = (state_ff != pac_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign n_use     = (32'(num_areas_ff) > MAX_AREAS) ? (AW+1)'(MAX_AREAS)
                                                       : (AW+1)'(num_areas_ff);
   assign slot      = {2'b00, top_first_ff} + {1'b0, top_pos_ff};

   assign rsp_valid     = rsp_ff.valid;
   assign rsp_connected = rsp_ff.connected;
   assign rsp_status    = rsp_ff.status;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_areas_ff   <= '0;
         last_portal_ff <= '0;
         no_areas_ff    <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (pac_pkg::pac_csr_type'(csr_index))
            pac_pkg::CSR_NUM_AREAS:   num_areas_ff   <= csr_wdata[8:0];
            pac_pkg::CSR_LAST_PORTAL: last_portal_ff <= csr_wdata;
            pac_pkg::CSR_NO_AREAS:    no_areas_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pac_pkg::ST_CLEAR;
         rsp_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         rsp_ff   <= rsp_in;
         cnt_ff   <= cnt_in;
      end
      i_ff         <= i_in;
      lbl_ff       <= lbl_in;
      sp_ff        <= sp_in;
      top_area_ff  <= top_area_in;
      top_pos_ff   <= top_pos_in;
      top_first_ff <= top_first_in;
      top_count_ff <= top_count_in;
      other_ff     <= other_in;
      other_ok_ff  <= other_ok_in;
      qa_ff        <= qa_in;
      qb_ff        <= qb_in;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_in       = '0;
      cnt_in       = cnt_ff;
      i_in         = i_ff;
      lbl_in       = lbl_ff;
      sp_in        = sp_ff;
      top_area_in  = top_area_ff;
      top_pos_in   = top_pos_ff;
      top_first_in = top_first_ff;
      top_count_in = top_count_ff;
      other_in     = other_ff;
      other_ok_in  = other_ok_ff;
      qa_in        = qa_ff;
      qb_in        = qb_ff;

      span_we     = 1'b0;
      span_raddr  = top_area_ff;
      edge_we     = 1'b0;
      edge_raddr  = EW'(slot);
      port_we     = 1'b0;
      port_waddr  = PW'(req_portal_index);
      port_wdata  = req_open_flag;
      port_raddr  = PW'(edge_rd[17:8]);
      lab_we      = 1'b0;
      lab_waddr   = other_ff;
      lab_wdata   = lbl_ff;
      lab_raddr_a = other_ff;
      lab_raddr_b = AW'(req_area_b);
      vis_we      = 1'b0;
      vis_waddr   = other_ff;
      vis_wdata   = 1'b1;
      vis_raddr   = other_ff;
      stk_we      = 1'b0;
      stk_waddr   = AW'(sp_ff - 1'b1);
      stk_raddr   = AW'(sp_ff - 2'd2);

      case (state_ff)
         pac_pkg::ST_CLEAR: begin
            port_waddr = PW'(cnt_ff);
            port_wdata = 1'b0;
            port_we    = (32'(cnt_ff) < MAX_PORTALS);
            lab_waddr  = AW'(cnt_ff);
            lab_wdata  = '0;
            lab_we     = (32'(cnt_ff) < MAX_AREAS);
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == CW'(CLR - 1)) begin
               state_in = pac_pkg::ST_IDLE;
            end
         end
         pac_pkg::ST_IDLE: begin
            lab_raddr_a = AW'(req_area_a);
            qa_in       = req_area_a;
            qb_in       = req_area_b;
            if (accept) begin
               rsp_in.valid = 1'b1;
               case (pac_pkg::pac_req_type'(req_type))
                  pac_pkg::REQ_SPAN: begin
                     if (32'(req_area_a) >= MAX_AREAS) begin
                        rsp_in.status = pac_pkg::STAT_RANGE;
                     end else begin
                        span_we = 1'b1;
                     end
                  end
                  pac_pkg::REQ_EDGE: begin
                     if (32'(req_edge_index) >= MAX_EDGES) begin
                        rsp_in.status = pac_pkg::STAT_RANGE;
                     end else begin
                        edge_we = 1'b1;
                     end
                  end
                  pac_pkg::REQ_PORTAL: begin
                     if (req_portal_index > last_portal_ff ||
                         32'(req_portal_index) >= MAX_PORTALS) begin
                        rsp_in.status = pac_pkg::STAT_IGNORED;
                     end else begin
                        port_we      = 1'b1;
                        rsp_in.valid = 1'b0;
                        cnt_in       = '0;
                        state_in     = pac_pkg::ST_VCLR;
                     end
                  end
                  default: begin
                     rsp_in.valid = 1'b0;
                     state_in     = pac_pkg::ST_QUERY;
                  end
               endcase
            end
         end
         pac_pkg::ST_QUERY: begin
            rsp_in.valid = 1'b1;
            if (no_areas_ff) begin
               rsp_in.connected = 1'b1;
            end else if (qa_ff == '0 || qb_ff == '0) begin
               rsp_in.connected = 1'b0;
            end else if (32'(qa_ff) >= 32'(n_use) || 32'(qb_ff) >= 32'(n_use)) begin
               rsp_in.status = pac_pkg::STAT_RANGE;
            end else begin
               rsp_in.connected = (lab_rd_a == lab_rd_b);
            end
            state_in = pac_pkg::ST_IDLE;
         end
         pac_pkg::ST_VCLR: begin
            vis_we    = 1'b1;
            vis_waddr = AW'(cnt_ff);
            vis_wdata = 1'b0;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == CW'(MAX_AREAS - 1)) begin
               i_in     = (AW+1)'(1);
               lbl_in   = '0;
               state_in = pac_pkg::ST_SCAN;
            end
         end
         pac_pkg::ST_SCAN: begin
            vis_raddr = i_ff[AW-1:0];
            if (i_ff >= n_use) begin
               rsp_in.valid = 1'b1;
               state_in     = pac_pkg::ST_IDLE;
            end else begin
               state_in = pac_pkg::ST_SCANW;
            end
         end
         pac_pkg::ST_SCANW: begin
            if (vis_rd) begin
               i_in     = i_ff + 1'b1;
               state_in = pac_pkg::ST_SCAN;
            end else begin
               // new root: label it and start the walk
               lbl_in      = lbl_ff + 1'b1;
               lab_we      = 1'b1;
               lab_waddr   = i_ff[AW-1:0];
               lab_wdata   = lbl_ff + 1'b1;
               vis_we      = 1'b1;
               vis_waddr   = i_ff[AW-1:0];
               top_area_in = i_ff[AW-1:0];
               top_pos_in  = '0;
               sp_in       = (AW+1)'(1);
               span_raddr  = i_ff[AW-1:0];
               state_in    = pac_pkg::ST_SPANW;
            end
         end
         pac_pkg::ST_SPANW: begin
            top_first_in = span_rd[20:11];
            top_count_in = span_rd[10:0];
            state_in     = pac_pkg::ST_EDGE;
         end
         pac_pkg::ST_EDGE: begin
            if (top_pos_ff >= top_count_ff || 32'(slot) >= MAX_EDGES) begin
               // pop the finished area
               if (sp_ff == (AW+1)'(1)) begin
                  sp_in    = '0;
                  i_in     = i_ff + 1'b1;
                  state_in = pac_pkg::ST_SCAN;
               end else begin
                  sp_in    = sp_ff - 1'b1;
                  state_in = pac_pkg::ST_POPW;
               end
            end else begin
               top_pos_in = top_pos_ff + 1'b1;
               state_in   = pac_pkg::ST_EDGEW;
            end
         end
         pac_pkg::ST_EDGEW: begin
            other_in    = AW'(edge_rd[7:0]);
            other_ok_in = (32'(edge_rd[7:0]) < MAX_AREAS);
            if (32'(edge_rd[17:8]) >= MAX_PORTALS) begin
               state_in = pac_pkg::ST_EDGE;
            end else begin
               state_in = pac_pkg::ST_PORTW;
            end
         end
         pac_pkg::ST_PORTW: begin
            if (port_rd && other_ok_ff) begin
               state_in = pac_pkg::ST_VISW;
            end else begin
               state_in = pac_pkg::ST_EDGE;
            end
         end
         pac_pkg::ST_VISW: begin
            if (vis_rd) begin
               if (lab_rd_a == lbl_ff) begin
                  state_in = pac_pkg::ST_EDGE;
               end else begin
                  rsp_in.valid  = 1'b1;
                  rsp_in.status = pac_pkg::STAT_CONFLICT;
                  state_in      = pac_pkg::ST_IDLE;
               end
            end else begin
               lab_we = 1'b1;
               vis_we = 1'b1;
               if (32'(sp_ff) >= MAX_AREAS) begin
                  state_in = pac_pkg::ST_EDGE;
               end else begin
                  // push the current area and descend
                  stk_we      = 1'b1;
                  top_area_in = other_ff;
                  top_pos_in  = '0;
                  sp_in       = sp_ff + 1'b1;
                  span_raddr  = other_ff;
                  state_in    = pac_pkg::ST_SPANW;
               end
            end
         end
         pac_pkg::ST_POPW: begin
            top_area_in = stk_rd[SW-1:11];
            top_pos_in  = stk_rd[10:0];
            span_raddr  = stk_rd[SW-1:11];
            state_in    = pac_pkg::ST_SPANW;
         end
         default: begin
            state_in = pac_pkg::ST_IDLE;
         end
      endcase
   end

   pac_ram #(.WIDTH(21), .DEPTH(MAX_AREAS)) u_span (
      .clock   (clock),
      .wr_en   (span_we),
      .wr_addr (AW'(req_area_a)),
      .wr_data ({req_edge_index, req_edge_count}),
      .rd_addr (span_raddr),
      .rd_data (span_rd)
   );

   pac_ram #(.WIDTH(18), .DEPTH(MAX_EDGES)) u_edge (
      .clock   (clock),
      .wr_en   (edge_we),
      .wr_addr (EW'(req_edge_index)),
      .wr_data ({req_portal_index, req_area_b}),
      .rd_addr (edge_raddr),
      .rd_data (edge_rd)
   );

   pac_ram #(.WIDTH(1), .DEPTH(MAX_PORTALS)) u_portal (
      .clock   (clock),
      .wr_en   (port_we),
      .wr_addr (port_waddr),
      .wr_data (port_wdata),
      .rd_addr (port_raddr),
      .rd_data (port_rd)
   );

   // two copies of the label memory give two read ports
   pac_ram #(.WIDTH(8), .DEPTH(MAX_AREAS)) u_label_a (
      .clock   (clock),
      .wr_en   (lab_we),
      .wr_addr (lab_waddr),
      .wr_data (lab_wdata),
      .rd_addr (lab_raddr_a),
      .rd_data (lab_rd_a)
   );

   pac_ram #(.WIDTH(8), .DEPTH(MAX_AREAS)) u_label_b (
      .clock   (clock),
      .wr_en   (lab_we),
      .wr_addr (lab_waddr),
      .wr_data (lab_wdata),
      .rd_addr (lab_raddr_b),
      .rd_data (lab_rd_b)
   );

   pac_ram #(.WIDTH(1), .DEPTH(MAX_AREAS)) u_visited (
      .clock   (clock),
      .wr_en   (vis_we),
      .wr_addr (vis_waddr),
      .wr_data (vis_wdata),
      .rd_addr (vis_raddr),
      .rd_data (vis_rd)
   );

   pac_ram #(.WIDTH(SW), .DEPTH(MAX_AREAS)) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data ({top_area_ff, top_pos_ff}),
      .rd_addr (stk_raddr),
      .rd_data (stk_rd)
   );

endmodule

>>> sv/pac_checker.sv
// ----------------------------------------------------------------------------
// pac_checker
// Port-level timing and response checks for the portal area connectivity block.
// ----------------------------------------------------------------------------
module pac_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [1:0] req_type,
   input logic       rsp_valid,
   input logic       rsp_connected,
   input logic [1:0] rsp_status
);

   // loads answer on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_type == pac_pkg::REQ_SPAN || req_type == pac_pkg::REQ_EDGE))
      |=> rsp_valid)
      else $error("load item not answered on next cycle");

   // queries answer through the query state and the registered response
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_type == pac_pkg::REQ_QUERY) |-> ##2 rsp_valid)
      else $error("query item not answered after two cycles");

   // any failure status carries a cleared answer
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != pac_pkg::STAT_DONE) |-> !rsp_connected)
      else $error("connected set with failure status");

   // the memory sweep holds the block busy after reset
   assert property (@(posedge clock)
      $past(reset) |-> busy)
      else $error("block not busy after reset");

endmodule

bind portal_area_connectivity pac_checker u_pac_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_type      (req_type),
   .rsp_valid     (rsp_valid),
   .rsp_connected (rsp_connected),
   .rsp_status    (rsp_status)
);
